// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, masked while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Condition that must never be seen on a rising clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

// ===== rtl/fmv_pkg.sv =====
package fmv_pkg;

   // Result status codes, in order of the check that raises them.
   typedef enum logic [3:0] {
      STATUS_OK           = 4'd0,
      STATUS_NO_SOH_END   = 4'd1,
      STATUS_NO_EQUALS    = 4'd2,
      STATUS_TAG_NONDIGIT = 4'd3,
      STATUS_HDR_FIRST    = 4'd4,
      STATUS_HDR_SECOND   = 4'd5,
      STATUS_HDR_THIRD    = 4'd6,
      STATUS_BAD_TYPE     = 4'd7,
      STATUS_BAD_PRICE    = 4'd8,
      STATUS_BAD_QUANTITY = 4'd9
   } fmv_status_type;

   // One message byte as it is transferred on the request channel.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } fmv_req_type;

   // One result as it is transferred on the response channel.
   typedef struct packed {
      fmv_status_type status;
      logic [1:0]     order_kind;
      logic [30:0]    price;
      logic [30:0]    quantity;
   } fmv_rsp_type;

   // Characters of the message syntax.
   localparam logic [7:0] SOH_CHAR    = 8'h01;
   localparam logic [7:0] EQUALS_CHAR = 8'h3D;
   localparam logic [7:0] ZERO_CHAR   = 8'h30;
   localparam logic [7:0] ONE_CHAR    = 8'h31;
   localparam logic [7:0] TWO_CHAR    = 8'h32;
   localparam logic [7:0] NINE_CHAR   = 8'h39;

   // Tag numbers that the checks look for.
   localparam logic [6:0] TAG_BEGIN_STRING = 7'd8;
   localparam logic [6:0] TAG_BODY_LENGTH  = 7'd9;
   localparam logic [6:0] TAG_MSG_TYPE     = 7'd35;
   localparam logic [6:0] TAG_ORDER_QTY    = 7'd38;
   localparam logic [6:0] TAG_ORDER_TYPE   = 7'd40;
   localparam logic [6:0] TAG_PRICE        = 7'd44;

   // Limit for price and quantity after reset.
   localparam logic [30:0] MAX_VALUE_RESET = 31'd1000000;

   // A tag matches only as exact text: one digit for tags below ten,
   // two digits without a leading zero for the others.
   function automatic logic fmv_tag_is(input logic       bad,
                                       input logic [1:0] len,
                                       input logic       leading_zero,
                                       input logic [6:0] code,
                                       input logic [6:0] tag);
      logic short_hit;
      logic long_hit;
      short_hit = (len == 2'd1) && (code == tag) && (tag < 7'd10);
      long_hit  = (len == 2'd2) && !leading_zero && (code == tag) && (tag >= 7'd10);
      return !bad && (short_hit || long_hit);
   endfunction

endpackage

// ===== rtl/fmv_parser.sv =====
`include "assert_macros.svh"

module fmv_parser #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [30:0]         csr_wr_data,
   input  logic                step_valid,
   input  fmv_pkg::fmv_req_type step_data,
   output logic                res_valid,
   output fmv_pkg::fmv_rsp_type res_data
);
   import fmv_pkg::*;

   localparam int ACC_W = VALUE_WIDTH + 4;
   localparam int CMP_W = (VALUE_WIDTH > 31) ? VALUE_WIDTH : 31;

   // Limit register.
   logic [30:0] max_value_ff, max_value_in;

   // Per-field state.
   logic                   in_value_ff, in_value_in;
   logic [6:0]             tag_code_ff, tag_code_in;
   logic [1:0]             tag_length_ff, tag_length_in;
   logic                   tag_leading_zero_ff, tag_leading_zero_in;
   logic                   tag_bad_ff, tag_bad_in;
   logic [VALUE_WIDTH-1:0] value_acc_ff, value_acc_in;
   logic                   value_overflow_ff, value_overflow_in;
   logic [1:0]             value_length_ff, value_length_in;
   logic                   value_nondigit_ff, value_nondigit_in;
   logic [7:0]             value_first_char_ff, value_first_char_in;

   // Per-message state.
   logic [1:0]     field_index_ff, field_index_in;
   fmv_status_type first_error_ff, first_error_in;
   fmv_status_type header_error_ff, header_error_in;
   logic [1:0]     order_reg_ff, order_reg_in;
   logic [30:0]    price_reg_ff, price_reg_in;
   logic           price_ok_ff, price_ok_in;
   logic [30:0]    quantity_reg_ff, quantity_reg_in;
   logic           quantity_ok_ff, quantity_ok_in;

   // Byte classification.
   logic [7:0] cur_byte;
   logic       is_soh;
   logic       is_digit;
   assign cur_byte = step_data.data_byte;
   assign is_soh   = (cur_byte == SOH_CHAR);
   assign is_digit = (cur_byte >= ZERO_CHAR) && (cur_byte <= NINE_CHAR);

   // Tag matches on the field that closes with this byte.
   logic hit_type, hit_price, hit_qty, hit_header;
   logic [6:0] header_tag;
   fmv_status_type header_code;
   assign hit_type  = fmv_tag_is(tag_bad_ff, tag_length_ff, tag_leading_zero_ff,
                                 tag_code_ff, TAG_ORDER_TYPE);
   assign hit_price = fmv_tag_is(tag_bad_ff, tag_length_ff, tag_leading_zero_ff,
                                 tag_code_ff, TAG_PRICE);
   assign hit_qty   = fmv_tag_is(tag_bad_ff, tag_length_ff, tag_leading_zero_ff,
                                 tag_code_ff, TAG_ORDER_QTY);
   assign header_tag  = (field_index_ff == 2'd0) ? TAG_BEGIN_STRING :
                        (field_index_ff == 2'd1) ? TAG_BODY_LENGTH : TAG_MSG_TYPE;
   assign header_code = (field_index_ff == 2'd0) ? STATUS_HDR_FIRST :
                        (field_index_ff == 2'd1) ? STATUS_HDR_SECOND : STATUS_HDR_THIRD;
   assign hit_header = fmv_tag_is(tag_bad_ff, tag_length_ff, tag_leading_zero_ff,
                                  tag_code_ff, header_tag);

   // Value accumulator step: acc * 10 + digit, saturating at all ones.
   logic [ACC_W-1:0] acc_wide;
   logic [ACC_W-1:0] acc_next;
   logic             acc_over;
   assign acc_wide = ACC_W'(value_acc_ff);
   assign acc_next = (acc_wide << 3) + (acc_wide << 1) + ACC_W'(cur_byte[3:0]);
   assign acc_over = value_overflow_ff || (|acc_next[ACC_W-1:VALUE_WIDTH]);

   // Range check of the closing field's number.
   logic number_ok;
   assign number_ok = (value_length_ff != 2'd0) && !value_nondigit_ff &&
                      !value_overflow_ff && (value_acc_ff != '0) &&
                      (CMP_W'(value_acc_ff) <= CMP_W'(max_value_ff));

   assign max_value_in = csr_wr_en ? csr_wr_data : max_value_ff;

   // Byte update, result build and end-of-message clear.
   fmv_status_type hdr_final;
   always_comb begin
      in_value_in         = in_value_ff;
      tag_code_in         = tag_code_ff;
      tag_length_in       = tag_length_ff;
      tag_leading_zero_in = tag_leading_zero_ff;
      tag_bad_in          = tag_bad_ff;
      value_acc_in        = value_acc_ff;
      value_overflow_in   = value_overflow_ff;
      value_length_in     = value_length_ff;
      value_nondigit_in   = value_nondigit_ff;
      value_first_char_in = value_first_char_ff;
      field_index_in      = field_index_ff;
      first_error_in      = first_error_ff;
      header_error_in     = header_error_ff;
      order_reg_in        = order_reg_ff;
      price_reg_in        = price_reg_ff;
      price_ok_in         = price_ok_ff;
      quantity_reg_in     = quantity_reg_ff;
      quantity_ok_in      = quantity_ok_ff;
      hdr_final           = STATUS_OK;
      res_valid           = 1'b0;
      res_data            = '0;

      if (step_valid) begin
         if (is_soh) begin
            // Close the field.
            if (!in_value_ff) begin
               if (first_error_ff == STATUS_OK) begin
                  first_error_in = STATUS_NO_EQUALS;
               end
            end else begin
               if (tag_bad_ff && first_error_ff == STATUS_OK) begin
                  first_error_in = STATUS_TAG_NONDIGIT;
               end
               if (field_index_ff != 2'd3 && header_error_ff == STATUS_OK && !hit_header) begin
                  header_error_in = header_code;
               end
               if (hit_type) begin
                  if (value_length_ff == 2'd1 &&
                      (value_first_char_ff == ONE_CHAR || value_first_char_ff == TWO_CHAR)) begin
                     order_reg_in = value_first_char_ff[1:0];
                  end else begin
                     order_reg_in = 2'd0;
                  end
               end else if (hit_price) begin
                  price_ok_in  = number_ok;
                  price_reg_in = number_ok ? 31'(value_acc_ff) : 31'd0;
               end else if (hit_qty) begin
                  quantity_ok_in  = number_ok;
                  quantity_reg_in = number_ok ? 31'(value_acc_ff) : 31'd0;
               end
            end
            if (field_index_ff != 2'd3) begin
               field_index_in = field_index_ff + 2'd1;
            end
            in_value_in         = 1'b0;
            tag_code_in         = '0;
            tag_length_in       = '0;
            tag_leading_zero_in = 1'b0;
            tag_bad_in          = 1'b0;
            value_acc_in        = '0;
            value_overflow_in   = 1'b0;
            value_length_in     = '0;
            value_nondigit_in   = 1'b0;
            value_first_char_in = '0;
         end else if (!in_value_ff) begin
            // Tag text.
            if (cur_byte == EQUALS_CHAR) begin
               in_value_in = 1'b1;
            end else if (is_digit) begin
               if (tag_length_ff == 2'd0 && cur_byte == ZERO_CHAR) begin
                  tag_leading_zero_in = 1'b1;
               end
               if (tag_length_ff < 2'd2) begin
                  tag_code_in = 7'((tag_code_ff << 3) + (tag_code_ff << 1)
                                   + 7'(cur_byte[3:0]));
               end
               if (tag_length_ff != 2'd3) begin
                  tag_length_in = tag_length_ff + 2'd1;
               end
            end else begin
               tag_bad_in = 1'b1;
            end
         end else begin
            // Value text.
            if (value_length_ff == 2'd0) begin
               value_first_char_in = cur_byte;
            end
            if (value_length_ff < 2'd2) begin
               value_length_in = value_length_ff + 2'd1;
            end
            if (is_digit) begin
               if (acc_over) begin
                  value_overflow_in = 1'b1;
                  value_acc_in      = '1;
               end else begin
                  value_acc_in = acc_next[VALUE_WIDTH-1:0];
               end
            end else begin
               value_nondigit_in = 1'b1;
            end
         end

         if (step_data.end_of_message) begin
            // Header code, with missing header fields counted as wrong.
            hdr_final = header_error_in;
            if (hdr_final == STATUS_OK) begin
               case (field_index_in)
                  2'd0:    hdr_final = STATUS_HDR_FIRST;
                  2'd1:    hdr_final = STATUS_HDR_SECOND;
                  2'd2:    hdr_final = STATUS_HDR_THIRD;
                  default: hdr_final = STATUS_OK;
               endcase
            end

            res_valid = 1'b1;
            if (!is_soh) begin
               res_data.status = STATUS_NO_SOH_END;
            end else if (first_error_in != STATUS_OK) begin
               res_data.status = first_error_in;
            end else if (hdr_final != STATUS_OK) begin
               res_data.status = hdr_final;
            end else if (order_reg_in == 2'd0) begin
               res_data.status = STATUS_BAD_TYPE;
            end else if (!price_ok_in) begin
               res_data.status = STATUS_BAD_PRICE;
            end else if (!quantity_ok_in) begin
               res_data.status = STATUS_BAD_QUANTITY;
            end else begin
               res_data.status = STATUS_OK;
            end
            res_data.order_kind = order_reg_in;
            res_data.price      = price_reg_in;
            res_data.quantity   = quantity_reg_in;

            // Start the next message from a clean state.
            in_value_in         = 1'b0;
            tag_code_in         = '0;
            tag_length_in       = '0;
            tag_leading_zero_in = 1'b0;
            tag_bad_in          = 1'b0;
            value_acc_in        = '0;
            value_overflow_in   = 1'b0;
            value_length_in     = '0;
            value_nondigit_in   = 1'b0;
            value_first_char_in = '0;
            field_index_in      = '0;
            first_error_in      = STATUS_OK;
            header_error_in     = STATUS_OK;
            order_reg_in        = '0;
            price_reg_in        = '0;
            price_ok_in         = 1'b0;
            quantity_reg_in     = '0;
            quantity_ok_in      = 1'b0;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff        <= MAX_VALUE_RESET;
         in_value_ff         <= 1'b0;
         tag_code_ff         <= '0;
         tag_length_ff       <= '0;
         tag_leading_zero_ff <= 1'b0;
         tag_bad_ff          <= 1'b0;
         value_acc_ff        <= '0;
         value_overflow_ff   <= 1'b0;
         value_length_ff     <= '0;
         value_nondigit_ff   <= 1'b0;
         value_first_char_ff <= '0;
         field_index_ff      <= '0;
         first_error_ff      <= STATUS_OK;
         header_error_ff     <= STATUS_OK;
         order_reg_ff        <= '0;
         price_reg_ff        <= '0;
         price_ok_ff         <= 1'b0;
         quantity_reg_ff     <= '0;
         quantity_ok_ff      <= 1'b0;
      end else begin
         max_value_ff        <= max_value_in;
         in_value_ff         <= in_value_in;
         tag_code_ff         <= tag_code_in;
         tag_length_ff       <= tag_length_in;
         tag_leading_zero_ff <= tag_leading_zero_in;
         tag_bad_ff          <= tag_bad_in;
         value_acc_ff        <= value_acc_in;
         value_overflow_ff   <= value_overflow_in;
         value_length_ff     <= value_length_in;
         value_nondigit_ff   <= value_nondigit_in;
         value_first_char_ff <= value_first_char_in;
         field_index_ff      <= field_index_in;
         first_error_ff      <= first_error_in;
         header_error_ff     <= header_error_in;
         order_reg_ff        <= order_reg_in;
         price_reg_ff        <= price_reg_in;
         price_ok_ff         <= price_ok_in;
         quantity_reg_ff     <= quantity_reg_in;
         quantity_ok_ff      <= quantity_ok_in;
      end
   end

   `ASSERT_CLKD(a_eom_clears, clock, reset,
                step_valid && step_data.end_of_message |=> field_index_ff == 2'd0 && !in_value_ff,
                "message state not cleared after end of message")
   `ASSERT_CLKD(a_price_needs_ok, clock, reset, price_reg_ff != 31'd0 |-> price_ok_ff,
                "price held without a valid range check")
   `ASSERT_NEVER(a_order_code, clock, reset, order_reg_ff == 2'd3,
                 "order type register holds an impossible code")

endmodule

// ===== rtl/fmv_out_reg.sv =====
`include "assert_macros.svh"

module fmv_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  fmv_pkg::fmv_rsp_type load_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output fmv_pkg::fmv_rsp_type rsp_data,
   output logic                 out_ready
);
   import fmv_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   fmv_rsp_type rsp_data_ff, rsp_data_in;

   // The slot can take a new result when empty or when its transfer completes.
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = load_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload register carries no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_CLKD(a_load_when_ready, clock, reset, load |-> out_ready,
                "result loaded over one still waiting")
   `ASSERT_CLKD(a_load_shows, clock, reset,
                load |=> rsp_valid_ff && rsp_data_ff == $past(load_data),
                "loaded result not presented")
   `ASSERT_CLKD(a_drain, clock, reset,
                rsp_valid_ff && !rsp_stall && !load |=> !rsp_valid_ff,
                "result presented again after its transfer")

endmodule

// ===== rtl/fix_message_validator.sv =====
// Channel   Ports                            Direction  Moves
// request   req_valid req_stall req_data     in         one message byte per transfer
// response  rsp_valid rsp_stall rsp_data     out        one result per message
// config    csr_wr_en csr_wr_data            in         price and quantity limit
//
// One byte is taken per cycle unless req_stall is high. A result is presented
// after the byte that ends its message has passed through the input register
// and then the result register.
// Reset is synchronous, clears all message state and restores the default limit.
// A held response stalls the request side only when the byte waiting in the
// input register ends a message; other bytes keep flowing.
module fix_message_validator #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fmv_pkg::fmv_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fmv_pkg::fmv_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [30:0]          csr_wr_data
);
   import fmv_pkg::*;

   logic        in_valid_ff, in_valid_in;
   fmv_req_type in_data_ff, in_data_in;
   logic        in_advance;
   logic        req_take;
   logic        out_ready;
   logic        res_valid;
   fmv_rsp_type res_data;

   // A byte leaves the input register unless it ends a message and the
   // result slot is occupied and stalled.
   assign in_advance = in_valid_ff && (!in_data_ff.end_of_message || out_ready);
   assign req_stall  = in_valid_ff && !in_advance;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      in_data_in = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (in_advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   fmv_parser #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_valid  (in_advance),
      .step_data   (in_data_ff),
      .res_valid   (res_valid),
      .res_data    (res_data)
   );

   fmv_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .out_ready (out_ready)
   );

endmodule

// ===== sim/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fmv_pkg::*;

   localparam int VALUE_BITS = 32;
   localparam longint unsigned NUM_SAT = {64{1'b1}} >> (64 - VALUE_BITS);
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   // Clock, reset and block ports.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   fmv_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   fmv_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [30:0] csr_wr_data = '0;

   fix_message_validator #(.VALUE_WIDTH(VALUE_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Stimulus and expectation stores, idle mix and run statistics.
   fmv_req_type pending_items[$];
   fmv_rsp_type expected_verdicts[$];
   logic [7:0]  msg_text[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_armed = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned results_seen = 0;
   int unsigned bytes_sent = 0;
   int unsigned limit_writes = 0;
   int unsigned cycle_count = 0;

   // Shadow of the parser: per-field and per-message state plus the limit.
   logic [30:0]     value_limit;
   int unsigned     fld_count;
   bit              in_val;
   int unsigned     tag_num;
   int unsigned     tag_chars;
   bit              tag_lead0;
   bit              tag_badc;
   longint unsigned num_acc;
   bit              num_ovf;
   int unsigned     num_chars;
   bit              num_bad;
   logic [7:0]      num_first;
   fmv_status_type  syntax_err;
   fmv_status_type  header_err;
   logic [1:0]      order_seen;
   logic [30:0]     price_seen;
   bit              price_valid;
   logic [30:0]     qty_seen;
   bit              qty_valid;

   function automatic void clear_field_state();
      in_val = 1'b0;
      tag_num = 0;
      tag_chars = 0;
      tag_lead0 = 1'b0;
      tag_badc = 1'b0;
      num_acc = 0;
      num_ovf = 1'b0;
      num_chars = 0;
      num_bad = 1'b0;
      num_first = '0;
   endfunction

   function automatic void clear_message_state();
      clear_field_state();
      fld_count = 0;
      syntax_err = STATUS_OK;
      header_err = STATUS_OK;
      order_seen = '0;
      price_seen = '0;
      price_valid = 1'b0;
      qty_seen = '0;
      qty_valid = 1'b0;
   endfunction

   function automatic fmv_status_type header_code(int unsigned idx);
      case (idx)
         0: return STATUS_HDR_FIRST;
         1: return STATUS_HDR_SECOND;
         default: return STATUS_HDR_THIRD;
      endcase
   endfunction

   // Tags compare as exact text: one digit below ten, two digits otherwise.
   function automatic bit tag_matches(logic [6:0] want);
      if (tag_badc) return 1'b0;
      if (tag_chars == 1) return tag_num == want && want < 10;
      if (tag_chars == 2) return !tag_lead0 && tag_num == want && want >= 10;
      return 1'b0;
   endfunction

   function automatic bit number_in_range();
      return num_chars != 0 && !num_bad && !num_ovf && num_acc >= 1 &&
             num_acc <= longint'(value_limit);
   endfunction

   // An SOH closes the current field and folds it into the message state.
   function automatic void close_field();
      logic [6:0] hdr_tag;
      if (!in_val) begin
         if (syntax_err == STATUS_OK) syntax_err = STATUS_NO_EQUALS;
      end else begin
         if (tag_badc && syntax_err == STATUS_OK) syntax_err = STATUS_TAG_NONDIGIT;
         case (fld_count)
            0: hdr_tag = TAG_BEGIN_STRING;
            1: hdr_tag = TAG_BODY_LENGTH;
            default: hdr_tag = TAG_MSG_TYPE;
         endcase
         if (fld_count < 3 && header_err == STATUS_OK && !tag_matches(hdr_tag))
            header_err = header_code(fld_count);
         if (tag_matches(TAG_ORDER_TYPE)) begin
            if (num_chars == 1 && num_first == ONE_CHAR) order_seen = 2'd1;
            else if (num_chars == 1 && num_first == TWO_CHAR) order_seen = 2'd2;
            else order_seen = 2'd0;
         end else if (tag_matches(TAG_PRICE)) begin
            price_valid = number_in_range();
            price_seen = price_valid ? num_acc[30:0] : '0;
         end else if (tag_matches(TAG_ORDER_QTY)) begin
            qty_valid = number_in_range();
            qty_seen = qty_valid ? num_acc[30:0] : '0;
         end
      end
      if (fld_count < 3) fld_count++;
      clear_field_state();
   endfunction

   function automatic void absorb_byte(logic [7:0] b);
      bit              digit;
      longint unsigned d;
      digit = b >= ZERO_CHAR && b <= NINE_CHAR;
      d = longint'(b) - longint'(ZERO_CHAR);
      if (b == SOH_CHAR) begin
         close_field();
      end else if (!in_val) begin
         if (b == EQUALS_CHAR) begin
            in_val = 1'b1;
         end else if (digit) begin
            if (tag_chars == 0 && b == ZERO_CHAR) tag_lead0 = 1'b1;
            if (tag_chars < 2) tag_num = tag_num * 10 + int'(d);
            if (tag_chars < 3) tag_chars++;
         end else begin
            tag_badc = 1'b1;
         end
      end else begin
         if (num_chars == 0) num_first = b;
         if (num_chars < 2) num_chars++;
         if (digit) begin
            // The accumulator saturates once the value no longer fits.
            if (num_ovf || num_acc > (NUM_SAT - d) / 10) begin
               num_ovf = 1'b1;
               num_acc = NUM_SAT;
            end else begin
               num_acc = num_acc * 10 + d;
            end
         end else begin
            num_bad = 1'b1;
         end
      end
   endfunction

   // Feeds one accepted byte; the final byte of a message yields a verdict.
   function automatic void predict_verdict(fmv_req_type item);
      fmv_rsp_type    v;
      fmv_status_type hdr;
      absorb_byte(item.data_byte);
      if (!item.end_of_message) return;
      hdr = header_err;
      if (hdr == STATUS_OK && fld_count < 3) hdr = header_code(fld_count);
      if (item.data_byte != SOH_CHAR) v.status = STATUS_NO_SOH_END;
      else if (syntax_err != STATUS_OK) v.status = syntax_err;
      else if (hdr != STATUS_OK) v.status = hdr;
      else if (order_seen == 2'd0) v.status = STATUS_BAD_TYPE;
      else if (!price_valid) v.status = STATUS_BAD_PRICE;
      else if (!qty_valid) v.status = STATUS_BAD_QUANTITY;
      else v.status = STATUS_OK;
      v.order_kind = order_seen;
      v.price = price_valid ? price_seen : '0;
      v.quantity = qty_valid ? qty_seen : '0;
      expected_verdicts.insert(expected_verdicts.size(), v);
      clear_message_state();
   endfunction

   function automatic void report_mismatch(string what, fmv_rsp_type want, fmv_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%s at result %0d: expected status %0d kind %0d price %0d quantity %0d,",
                  what, results_seen, want.status, want.order_kind, want.price,
                  want.quantity);
      if (mismatch_count <= MAX_REPORTS)
         $display("   got status %0d kind %0d price %0d quantity %0d",
                  got.status, got.order_kind, got.price, got.quantity);
   endfunction

   // Request driver: holds a stalled transfer, otherwise offers or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_verdict(req_data);
            bytes_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long response hold-off, started once when armed and counted down here.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_armed && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: checks each transfer and drives the stall pattern.
   always @(posedge clock) begin
      fmv_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("Unexpected result", '0, rsp_data);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.status !== want.status || rsp_data.order_kind !== want.order_kind ||
                   rsp_data.price !== want.price || rsp_data.quantity !== want.quantity)
                  report_mismatch("Mismatch", want, rsp_data);
            end
            results_seen++;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
   end

   // Message text builders.
   function automatic void append_byte(logic [7:0] b);
      msg_text.insert(msg_text.size(), b);
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endfunction

   function automatic void push_field(string tag, string val);
      push_text(tag);
      append_byte(EQUALS_CHAR);
      push_text(val);
      append_byte(SOH_CHAR);
   endfunction

   // Bytes that sit just outside the digits, at the byte extremes, or letters.
   function automatic logic [7:0] nondigit_byte();
      case ($urandom_range(4, 0))
         0: return 8'hFF;
         1: return 8'h00;
         2: return ZERO_CHAR - 8'd1;
         3: return NINE_CHAR + 8'd1;
         default: return 8'($urandom_range(90, 65));
      endcase
   endfunction

   function automatic void emit_order_value(bit spoil);
      if (!spoil) begin
         append_byte($urandom_range(1, 0) ? ONE_CHAR : TWO_CHAR);
         return;
      end
      case ($urandom_range(5, 0))
         0: ;
         1: push_text("0");
         2: push_text("3");
         3: push_text("12");
         4: append_byte(nondigit_byte());
         default: begin
            append_byte(ONE_CHAR);
            append_byte(nondigit_byte());
         end
      endcase
   endfunction

   // Price and quantity text, mostly in range, or one of the edge failures.
   function automatic void emit_number(bit spoil);
      if (!spoil) begin
         case ($urandom_range(3, 0))
            0: push_text("1");
            1: push_text($sformatf("%0d", value_limit));
            2: push_text($sformatf("%0d", $urandom_range(value_limit, 1)));
            default: push_text($sformatf("00%0d", $urandom_range(value_limit, 1)));
         endcase
         return;
      end
      case ($urandom_range(7, 0))
         0: push_text("0");
         1: push_text($sformatf("%0d", longint'(value_limit) + 1));
         2: ;
         3: push_text("4294967295");
         4: push_text("4294967296");
         5: push_text("99999999999999999999");
         6: begin
            push_text($sformatf("%0d", $urandom_range(99, 1)));
            append_byte(nondigit_byte());
         end
         default: begin
            append_byte(nondigit_byte());
            push_text("5");
         end
      endcase
   endfunction

   // One field; a spoiled field gets a bent tag, a missing '=' or a bad value.
   function automatic void emit_field(int unsigned tag, bit spoil);
      int unsigned how;
      logic [7:0]  b;
      how = spoil ? $urandom_range(6, 0) : 7;
      case (how)
         0: push_text($sformatf("0%0d", tag));
         1: begin
            push_text($sformatf("%0d", tag));
            append_byte(nondigit_byte());
         end
         2: ;
         3: push_text($sformatf("%0d%0d", tag, $urandom_range(9, 0)));
         5: push_text($sformatf("%0d", $urandom_range(999, 0)));
         default: push_text($sformatf("%0d", tag));
      endcase
      if (how != 4) append_byte(EQUALS_CHAR);
      if (tag == TAG_ORDER_TYPE) begin
         emit_order_value(how == 6);
      end else if (tag == TAG_PRICE || tag == TAG_ORDER_QTY) begin
         emit_number(how == 6);
      end else begin
         repeat ($urandom_range(4, 0)) begin
            b = 8'($urandom_range(255, 0));
            append_byte(b == SOH_CHAR ? EQUALS_CHAR : b);
         end
      end
      append_byte(SOH_CHAR);
   endfunction

   // Mostly well-formed orders with random content; some are spoiled,
   // cut short, carry trailing bytes, or are plain noise.
   function automatic void build_message();
      int unsigned shape;
      int unsigned spoil_pct;
      int unsigned hdr_n;
      int unsigned hdr_tags[3];
      int unsigned body_tags[$];
      int unsigned extra;
      msg_text.delete();
      shape = $urandom_range(99, 0);
      if (shape < 6) begin
         repeat ($urandom_range(10, 1)) append_byte(8'($urandom_range(255, 0)));
         return;
      end
      spoil_pct = (shape < 40) ? 25 : 0;
      hdr_tags[0] = TAG_BEGIN_STRING;
      hdr_tags[1] = TAG_BODY_LENGTH;
      hdr_tags[2] = TAG_MSG_TYPE;
      hdr_n = (shape < 12) ? $urandom_range(2, 0) : 3;
      for (int i = 0; i < hdr_n; i++)
         emit_field(hdr_tags[i], $urandom_range(99, 0) < spoil_pct);
      if (hdr_n == 3) begin
         if ($urandom_range(9, 0) != 0) body_tags.insert(0, TAG_ORDER_TYPE);
         if ($urandom_range(9, 0) != 0)
            body_tags.insert($urandom_range(body_tags.size(), 0), TAG_PRICE);
         if ($urandom_range(9, 0) != 0)
            body_tags.insert($urandom_range(body_tags.size(), 0), TAG_ORDER_QTY);
         repeat ($urandom_range(2, 0)) begin
            case ($urandom_range(3, 0))
               0: extra = TAG_ORDER_TYPE;
               1: extra = TAG_PRICE;
               2: extra = TAG_ORDER_QTY;
               default: extra = $urandom_range(999, 1);
            endcase
            body_tags.insert($urandom_range(body_tags.size(), 0), extra);
         end
         foreach (body_tags[i]) emit_field(body_tags[i], $urandom_range(99, 0) < spoil_pct);
      end
      // Bytes after the last SOH form no field and leave the end unterminated.
      if (msg_text.size() == 0 || (spoil_pct != 0 && $urandom_range(99, 0) < 15))
         repeat ($urandom_range(3, 1)) append_byte(nondigit_byte() | 8'h02);
   endfunction

   function automatic int unsigned queue_message();
      fmv_req_type item;
      int unsigned n;
      n = msg_text.size();
      foreach (msg_text[i]) begin
         item.data_byte = msg_text[i];
         item.end_of_message = (i == n - 1);
         pending_items.insert(pending_items.size(), item);
      end
      msg_text.delete();
      return n;
   endfunction

   task automatic drain_and_settle();
      while (pending_items.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [30:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      value_limit = v;
      limit_writes++;
   endtask

   task automatic run_phase(input logic [30:0] lim, input int unsigned tx_idle,
                            input int unsigned rx_idle, input int unsigned min_bytes,
                            input int unsigned min_msgs, input bit with_hold);
      int unsigned n_bytes;
      int unsigned n_msgs;
      n_bytes = 0;
      n_msgs = 0;
      write_limit(lim);
      send_idle_pct = tx_idle;
      recv_idle_pct = rx_idle;
      while (n_bytes < min_bytes || n_msgs < min_msgs) begin
         build_message();
         n_bytes += queue_message();
         n_msgs++;
      end
      if (with_hold) hold_armed = 1'b1;
      drain_and_settle();
   endtask

   // Main sequence.
   initial begin
      clear_message_state();
      value_limit = MAX_VALUE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed messages at the reset limit: byte extremes, a bare SOH,
      // an empty tag, and a clean order with price at the limit.
      send_idle_pct = 17;
      recv_idle_pct = 54;
      append_byte(8'hFF);
      void'(queue_message());
      append_byte(8'h00);
      void'(queue_message());
      append_byte(SOH_CHAR);
      void'(queue_message());
      append_byte(EQUALS_CHAR);
      append_byte(SOH_CHAR);
      void'(queue_message());
      push_field("8", "F");
      push_field("9", "");
      push_field("35", "D");
      push_field("40", "2");
      push_field("44", "1000000");
      push_field("38", "1");
      void'(queue_message());
      drain_and_settle();

      // Random orders over several limits and the three idle mixes.
      run_phase(31'h7FFF_FFFF, 17, 54, 240, 3, 1'b0);
      run_phase(31'd1, 17, 54, 80, 2, 1'b0);
      run_phase(31'($urandom_range(100000, 2)), 54, 17, 260, 4, 1'b1);
      run_phase(31'd0, 54, 17, 60, 2, 1'b0);
      run_phase(31'($urandom_range(32'h7FFF_FFFE, 2)), 0, 0, 250, 4, 1'b0);

      $display("Checked %0d results from %0d message bytes under %0d limit settings,",
               results_seen, bytes_sent, limit_writes + 1);
      $display("with three idle mixes and a %0d-cycle response hold-off; %0d mismatches.",
               HOLD_CYCLES, mismatch_count);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
